[src/line_cell_rasterizer_assert.svh]
// Assertion macros for the line cell rasteriser top level.
`ifndef LINE_CELL_RASTERIZER_ASSERT_SVH
`define LINE_CELL_RASTERIZER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define LCR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line_cell_rasterizer: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define LCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line_cell_rasterizer: next-cycle check failed");

`endif

[src/lcr_pkg.sv]
// Shared types for the line cell rasteriser.
package lcr_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } step_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic busy;
    logic cmd_pop;
    logic last;
  } step_status_t;

endpackage

[src/lcr_queue.sv]
// Two-word queue with a head and a tail register.
module lcr_queue import lcr_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output queue_status_t    status
);

  logic [WIDTH-1:0] head;
  logic [WIDTH-1:0] tail;
  logic             head_v;
  logic             tail_v;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !tail_v;
  assign do_pop  = pop && head_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      tail_v <= 1'b0;
    end else if (!head_v) begin
      head_v <= do_push;
    end else if (do_pop) begin
      // advance the tail word, or refill the head straight from the input
      if (tail_v) begin
        tail_v <= 1'b0;
      end else begin
        head_v <= do_push;
      end
    end else if (do_push) begin
      tail_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_v) begin
      if (do_push) head <= wdata;
    end else if (do_pop) begin
      if (tail_v) begin
        head <= tail;
      end else if (do_push) begin
        head <= wdata;
      end
    end else if (do_push) begin
      tail <= wdata;
    end
  end

  assign rdata        = head;
  assign status.full  = tail_v;
  assign status.empty = !head_v;

endmodule

[src/lcr_front.sv]
// Request front end: octant signs, spans and starting error term.
module lcr_front import lcr_pkg::*; #(
  parameter int COORD_BITS = 6
) (
  input  logic [COORD_BITS-1:0]   start_x,
  input  logic [COORD_BITS-1:0]   start_y,
  input  logic [COORD_BITS-1:0]   end_x,
  input  logic [COORD_BITS-1:0]   end_y,
  output logic [7*COORD_BITS+4:0] desc
);

  logic                         x_up;
  logic                         y_up;
  logic [COORD_BITS-1:0]        abs_dx;
  logic [COORD_BITS-1:0]        abs_dy;
  logic signed [COORD_BITS+2:0] err;

  always_comb begin
    x_up   = start_x < end_x;
    y_up   = start_y < end_y;
    abs_dx = x_up ? (end_x - start_x) : (start_x - end_x);
    abs_dy = y_up ? (end_y - start_y) : (start_y - end_y);
    err    = $signed({3'b000, abs_dx}) - $signed({3'b000, abs_dy});
  end

  assign desc = {start_x, start_y, end_x, end_y, abs_dx, abs_dy, err, !x_up, !y_up};

endmodule

[src/lcr_stepper.sv]
// Error-term stepper: walks one line, one cell per accepted word.
module lcr_stepper import lcr_pkg::*; #(
  parameter int COORD_BITS = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7*COORD_BITS+4:0] cmd_data,
  input  logic                    cmd_empty,
  input  logic                    out_full,
  output logic [COORD_BITS-1:0]   cell_x,
  output logic [COORD_BITS-1:0]   cell_y,
  output logic                    cell_last,
  output logic                    cell_valid,
  output step_status_t            status
);

  localparam int EW = COORD_BITS + 3;

  step_state_t            state;
  step_state_t            state_next;
  logic [COORD_BITS-1:0]  cur_x;
  logic [COORD_BITS-1:0]  cur_y;
  logic [COORD_BITS-1:0]  tgt_x;
  logic [COORD_BITS-1:0]  tgt_y;
  logic [COORD_BITS-1:0]  dx;
  logic [COORD_BITS-1:0]  dy;
  logic signed [EW-1:0]   err;
  logic                   sx_neg;
  logic                   sy_neg;
  logic [COORD_BITS-1:0]  count;

  logic [COORD_BITS-1:0]  d_cx, d_cy, d_tx, d_ty, d_dx, d_dy;
  logic signed [EW-1:0]   d_err;
  logic                   d_sxn, d_syn;

  logic signed [EW:0]     e2;
  logic signed [EW:0]     dx_ext;
  logic signed [EW:0]     neg_dy_ext;
  logic                   x_cond, x_done, x_step;
  logic                   y_cond, y_done, y_step;
  logic                   guard;
  logic                   take;
  logic                   load;
  logic signed [EW-1:0]   err_next;

  assign {d_cx, d_cy, d_tx, d_ty, d_dx, d_dy, d_err, d_sxn, d_syn} = cmd_data;

  always_comb begin
    e2         = {err, 1'b0};
    dx_ext     = $signed({4'b0000, dx});
    neg_dy_ext = -$signed({4'b0000, dy});
    x_cond     = e2 >= neg_dy_ext;
    x_done     = x_cond && (cur_x == tgt_x);
    x_step     = x_cond && !x_done;
    y_cond     = !x_done && (e2 <= dx_ext);
    y_done     = y_cond && (cur_y == tgt_y);
    y_step     = y_cond && !y_done;
    // cap the run at the grid size
    guard      = &count;
    err_next   = err - (y_step ? EW'(0) : EW'(0))
                     - (x_step ? $signed({3'b000, dy}) : EW'(0))
                     + (y_step ? $signed({3'b000, dx}) : EW'(0));
  end

  assign cell_valid = state == ST_RUN;
  assign cell_x     = cur_x;
  assign cell_y     = cur_y;
  assign cell_last  = x_done || y_done || guard;
  assign take       = cell_valid && !out_full;
  assign load       = (state == ST_IDLE) && !cmd_empty;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (take && cell_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_x  <= d_cx;
      cur_y  <= d_cy;
      tgt_x  <= d_tx;
      tgt_y  <= d_ty;
      dx     <= d_dx;
      dy     <= d_dy;
      err    <= d_err;
      sx_neg <= d_sxn;
      sy_neg <= d_syn;
      count  <= '0;
    end else if (take) begin
      err   <= err_next;
      count <= count + 1'b1;
      if (x_step) cur_x <= sx_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      if (y_step) cur_y <= sy_neg ? cur_y - 1'b1 : cur_y + 1'b1;
    end
  end

  assign status.busy    = state == ST_RUN;
  assign status.cmd_pop = load;
  assign status.last    = cell_last;

endmodule

[src/line_cell_rasterizer.sv]
// Line cell rasteriser: request queue in, stepped grid cells out.
//
// Input channel: drive start_x/start_y/end_x/end_y with push; a request is
// taken at a rising edge with push high and full low. Up to two requests
// wait in a command queue while an earlier line is still being stepped.
// Output channel: while empty is low, cell_x/cell_y/last_cell show the oldest
// cell; it leaves at a rising edge with pop high. Cells come from start to
// end, max(|dx|,|dy|)+1 of them, and last_cell marks the end cell.
// The first cell of a line into an idle block passes the command queue, the
// stepper load and the output queue before it is visible. The stepper loads
// a request while idle and then issues one cell per cycle while the output
// queue is not full; it takes no new request until the line's last cell.
// A stalled receiver fills the two-word output queue, the stepper holds its
// position, then the command queue fills and full rises; nothing is dropped.
// Reset (rst, synchronous) empties both queues and returns the stepper to
// idle; any request or cell in flight is discarded.
module line_cell_rasterizer import lcr_pkg::*; #(
  parameter int COORD_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  empty,
  input  logic                  pop,
  output logic [COORD_BITS-1:0] cell_x,
  output logic [COORD_BITS-1:0] cell_y,
  output logic                  last_cell
);

  `include "line_cell_rasterizer_assert.svh"

  localparam int DESC_W = 7 * COORD_BITS + 5;
  localparam int CELL_W = 2 * COORD_BITS + 1;

  logic [DESC_W-1:0]     desc_in;
  logic [DESC_W-1:0]     desc_out;
  queue_status_t         cmd_stat;
  queue_status_t         out_stat;
  step_status_t          step_stat;
  logic [COORD_BITS-1:0] st_x;
  logic [COORD_BITS-1:0] st_y;
  logic                  st_last;
  logic                  st_valid;

  lcr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .desc    (desc_in)
  );

  lcr_queue #(.WIDTH(DESC_W)) u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (desc_in),
    .pop    (step_stat.cmd_pop),
    .rdata  (desc_out),
    .status (cmd_stat)
  );

  lcr_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
    .clk        (clk),
    .rst        (rst),
    .cmd_data   (desc_out),
    .cmd_empty  (cmd_stat.empty),
    .out_full   (out_stat.full),
    .cell_x     (st_x),
    .cell_y     (st_y),
    .cell_last  (st_last),
    .cell_valid (st_valid),
    .status     (step_stat)
  );

  lcr_queue #(.WIDTH(CELL_W)) u_out_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (st_valid),
    .wdata  ({st_x, st_y, st_last}),
    .pop    (pop),
    .rdata  ({cell_x, cell_y, last_cell}),
    .status (out_stat)
  );

  assign full  = cmd_stat.full;
  assign empty = out_stat.empty;

  `LCR_ASSERT_NOW(a_load_only_idle, clk, rst, step_stat.cmd_pop, !step_stat.busy)
  `LCR_ASSERT_NEXT(a_load_starts_run, clk, rst, step_stat.cmd_pop, step_stat.busy)
  `LCR_ASSERT_NEXT(a_run_to_last, clk, rst, step_stat.busy && !out_stat.full && !step_stat.last, step_stat.busy)

endmodule

[verif/line_cell_rasterizer_test.sv]
// Self-checking testbench for the line cell rasteriser: directed lines, random lines, idling phases.
module line_cell_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS   = 6;
  localparam int CELLS_MAX    = 1 << COORD_BITS;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = CELLS_MAX + 8;
  localparam int PHASE_ITEMS  = 72;
  localparam int TABLE_ROWS   = 24;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } cell_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   typed;
    cell_t  word;
  } line_row_t;

  localparam cell_t NO_CELL = '0;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   push = 1'b0;
  logic   full;
  coord_t start_x = '0;
  coord_t start_y = '0;
  coord_t end_x = '0;
  coord_t end_y = '0;
  logic   empty;
  logic   pop = 1'b0;
  coord_t cell_x;
  coord_t cell_y;
  logic   last_cell;

  cell_t cells_due [$];
  int    fails = 0;
  int    cycle_count = 0;
  int    send_idle_pct = 0;
  int    pop_stall_pct = 0;

  // Single-cell rows are typed in; the rest go through the line predictor.
  line_row_t line_table [TABLE_ROWS] = '{
    '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1, '{6'd0,  6'd0,  1'b1}},
    '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1, '{6'd63, 6'd63, 1'b1}},
    '{6'd0,  6'd63, 6'd0,  6'd63, 1'b1, '{6'd0,  6'd63, 1'b1}},
    '{6'd63, 6'd0,  6'd63, 6'd0,  1'b1, '{6'd63, 6'd0,  1'b1}},
    '{6'd37, 6'd42, 6'd37, 6'd42, 1'b1, '{6'd37, 6'd42, 1'b1}},
    '{6'd0,  6'd0,  6'd63, 6'd0,  1'b0, NO_CELL},
    '{6'd63, 6'd0,  6'd0,  6'd0,  1'b0, NO_CELL},
    '{6'd0,  6'd0,  6'd0,  6'd63, 1'b0, NO_CELL},
    '{6'd0,  6'd63, 6'd0,  6'd0,  1'b0, NO_CELL},
    '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0, NO_CELL},
    '{6'd63, 6'd63, 6'd0,  6'd0,  1'b0, NO_CELL},
    '{6'd0,  6'd63, 6'd63, 6'd0,  1'b0, NO_CELL},
    '{6'd63, 6'd0,  6'd0,  6'd63, 1'b0, NO_CELL},
    '{6'd0,  6'd0,  6'd63, 6'd1,  1'b0, NO_CELL},
    '{6'd1,  6'd0,  6'd0,  6'd63, 1'b0, NO_CELL},
    '{6'd10, 6'd10, 6'd20, 6'd13, 1'b0, NO_CELL},
    '{6'd10, 6'd10, 6'd13, 6'd20, 1'b0, NO_CELL},
    '{6'd20, 6'd20, 6'd10, 6'd17, 1'b0, NO_CELL},
    '{6'd20, 6'd20, 6'd17, 6'd10, 1'b0, NO_CELL},
    '{6'd5,  6'd40, 6'd40, 6'd5,  1'b0, NO_CELL},
    '{6'd1,  6'd2,  6'd62, 6'd61, 1'b0, NO_CELL},
    '{6'd30, 6'd30, 6'd31, 6'd31, 1'b0, NO_CELL},
    '{6'd30, 6'd30, 6'd31, 6'd30, 1'b0, NO_CELL},
    '{6'd31, 6'd30, 6'd30, 6'd30, 1'b0, NO_CELL}
  };

  line_cell_rasterizer #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .empty    (empty),
    .pop      (pop),
    .cell_x   (cell_x),
    .cell_y   (cell_y),
    .last_cell(last_cell)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue every cell of the line from (sx,sy) to (ex,ey), error-term stepping.
  function automatic void trace_line(input coord_t sx, input coord_t sy,
                                     input coord_t ex, input coord_t ey);
    coord_t                       cx;
    coord_t                       cy;
    coord_t                       dx;
    coord_t                       dy;
    logic signed [COORD_BITS:0]   sdx;
    logic signed [COORD_BITS:0]   ndy;
    logic signed [COORD_BITS+2:0] err;
    logic signed [COORD_BITS+3:0] e2;
    logic                         x_down;
    logic                         y_down;
    logic                         at_end;
    cell_t                        word;
    int                           n;
    cx = sx;
    cy = sy;
    x_down = !(sx < ex);
    y_down = !(sy < ey);
    dx = x_down ? sx - ex : ex - sx;
    dy = y_down ? sy - ey : ey - sy;
    sdx = $signed({1'b0, dx});
    ndy = -$signed({1'b0, dy});
    err = sdx + ndy;
    at_end = 1'b0;
    n = 0;
    while (!at_end) begin
      word.x = cx;
      word.y = cy;
      if (n + 1 >= CELLS_MAX) begin
        word.last = 1'b1;
        cells_due = {cells_due, word};
        break;
      end
      e2 = {err, 1'b0};
      if (e2 >= ndy) begin
        if (cx == ex) at_end = 1'b1;
        else begin
          err = err + ndy;
          cx = x_down ? cx - 1'b1 : cx + 1'b1;
        end
      end
      if (!at_end && e2 <= sdx) begin
        if (cy == ey) at_end = 1'b1;
        else begin
          err = err + sdx;
          cy = y_down ? cy - 1'b1 : cy + 1'b1;
        end
      end
      word.last = at_end;
      cells_due = {cells_due, word};
      n++;
    end
  endfunction

  // Offer one line; hold it until taken, then maybe idle for a while.
  task automatic send_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey, input logic typed, input cell_t word);
    start_x <= sx;
    start_y <= sy;
    end_x   <= ex;
    end_y   <= ey;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (typed) cells_due = {cells_due, word};
    else trace_line(sx, sy, ex, ey);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  function automatic coord_t near_coord(input coord_t c);
    int t;
    t = int'(c) + $urandom_range(8) - 4;
    if (t < 0) t = 0;
    if (t > CELLS_MAX - 1) t = CELLS_MAX - 1;
    return coord_t'(t);
  endfunction

  task automatic send_random_line();
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    int     kind;
    sx = coord_t'($urandom_range(CELLS_MAX - 1));
    sy = coord_t'($urandom_range(CELLS_MAX - 1));
    ex = coord_t'($urandom_range(CELLS_MAX - 1));
    ey = coord_t'($urandom_range(CELLS_MAX - 1));
    kind = $urandom_range(9);
    case (kind)
      0: begin
        ex = sx;
        ey = sy;
      end
      1: begin
        if ($urandom_range(1)) ey = sy;
        else ex = sx;
      end
      2, 3, 4, 5: begin
        ex = near_coord(sx);
        ey = near_coord(sy);
      end
      default: ;
    endcase
    send_line(sx, sy, ex, ey, 1'b0, NO_CELL);
  endtask

  // Check each word taken against the oldest cell due.
  always @(posedge clk) begin : cell_check
    cell_t due;
    if (rst) pop <= 1'b0;
    else begin
      if (pop && !empty) begin
        if (cells_due.size() == 0) begin
          $error("unexpected cell (%0d,%0d) last=%0b", cell_x, cell_y, last_cell);
          fails++;
        end else begin
          due = cells_due.pop_front();
          if (cell_x !== due.x) begin
            $error("cell_x: expected %0d, got %0d", due.x, cell_x);
            fails++;
          end
          if (cell_y !== due.y) begin
            $error("cell_y: expected %0d, got %0d", due.y, cell_y);
            fails++;
          end
          if (last_cell !== due.last) begin
            $error("last_cell: expected %0b, got %0b", due.last, last_cell);
            fails++;
          end
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** line_cell_rasterizer: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (line_table[i])
      send_line(line_table[i].sx, line_table[i].sy, line_table[i].ex, line_table[i].ey,
                line_table[i].typed, line_table[i].word);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  pop_stall_pct <= 0;  end
        1: begin send_idle_pct = 76; pop_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct <= 76; end
        default: begin send_idle_pct = 9; pop_stall_pct <= 9; end
      endcase
      repeat (PHASE_ITEMS) send_random_line();
    end

    push <= 1'b0;
    pop_stall_pct <= 0;
    while (cells_due.size() != 0) @(posedge clk);
    // catch any stray cell after the last one due
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) $display("** line_cell_rasterizer: PASSED **");
    else $display("** line_cell_rasterizer: FAILED **");
    $finish;
  end

endmodule
